>>> hdl/sorted_unique_key_table_unit_defines.svh
// assertion macros for the sorted unique key table unit
`ifndef SORTED_UNIQUE_KEY_TABLE_UNIT_DEFINES_SVH
`define SORTED_UNIQUE_KEY_TABLE_UNIT_DEFINES_SVH
`ifndef SYNTH
`define SKUT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sorted key table assertion failed");
`define SKUT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted key table assertion failed");
`else
`define SKUT_ASSERT_NOW(label, ante, cons)
`define SKUT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> hdl/skut_pkg.sv
// shared types and constants of the sorted unique key table unit
package skut_pkg;

   localparam int OP_W      = 2;
   localparam int STATUS_W  = 3;
   localparam int KEY_W     = 32;
   localparam int PAYLOAD_W = 64;
   localparam int RANK_W    = 7;
   localparam int COUNT_W   = 7;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED   = 3'd0,
      ST_DUPLICATE  = 3'd1,
      ST_FULL       = 3'd2,
      ST_DELETED    = 3'd3,
      ST_ABSENT     = 3'd4,
      ST_HIT        = 3'd5,
      ST_RANK_EMPTY = 3'd6,
      ST_UNUSED     = 3'd7
   } status_type;

   typedef struct packed {
      logic capture;
      logic shift_ins;
      logic shift_del;
   } cell_ctl_type;

endpackage

>>> hdl/skut_cell.sv
// one cell of the sorted key row: holds one record and compares it against the request
module skut_cell import skut_pkg::*; #(
   parameter int KEY_BITS = 32,
   parameter int INDEX    = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cell_ctl_type               ctl,
   input  logic                       occupied,
   input  logic signed [KEY_BITS-1:0] key_cmp,
   input  logic [RANK_W-1:0]          rank_cmp,
   input  logic signed [KEY_BITS-1:0] key_new,
   input  logic [PAYLOAD_W-1:0]       pay_new,
   input  logic                       left_lt,
   input  logic signed [KEY_BITS-1:0] left_key,
   input  logic [PAYLOAD_W-1:0]       left_pay,
   input  logic signed [KEY_BITS-1:0] right_key,
   input  logic [PAYLOAD_W-1:0]       right_pay,
   output logic                       lt,
   output logic                       eq,
   output logic                       hit,
   output logic signed [KEY_BITS-1:0] key,
   output logic [PAYLOAD_W-1:0]       pay
);

   localparam int RANK_LIMIT = 1 << RANK_W;

   logic                       lt_ff, lt_in;
   logic                       eq_ff, eq_in;
   logic                       hit_ff, hit_in;
   logic signed [KEY_BITS-1:0] key_ff, key_in;
   logic [PAYLOAD_W-1:0]       pay_ff, pay_in;
   logic                       rank_match;

   assign rank_match = (INDEX + 1 < RANK_LIMIT) && (rank_cmp == RANK_W'(INDEX + 1));

   always_comb begin
      lt_in  = lt_ff;
      eq_in  = eq_ff;
      hit_in = hit_ff;
      if (ctl.capture) begin
         lt_in  = occupied && (key_ff < key_cmp);
         eq_in  = occupied && (key_ff == key_cmp);
         hit_in = occupied && rank_match;
      end
   end

   always_comb begin
      key_in = key_ff;
      pay_in = pay_ff;
      if (ctl.shift_ins && !lt_ff) begin
         if (left_lt) begin
            key_in = key_new;
            pay_in = pay_new;
         end else begin
            key_in = left_key;
            pay_in = left_pay;
         end
      end else if (ctl.shift_del && !lt_ff) begin
         key_in = right_key;
         pay_in = right_pay;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lt_ff  <= 1'b0;
         eq_ff  <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         lt_ff  <= lt_in;
         eq_ff  <= eq_in;
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      pay_ff <= pay_in;
   end

   assign lt  = lt_ff;
   assign eq  = eq_ff;
   assign hit = hit_ff;
   assign key = key_ff;
   assign pay = pay_ff;

endmodule

>>> hdl/sorted_unique_key_table_unit.sv
// top level of the sorted unique key table: a row of record cells and its control
//
//   channel   direction  transfer when            payload
//   req_      in         req_valid && req_ready   operation, key_value, payload_in, rank_in
//   rsp_      out        rsp_valid && rsp_ready   status, key_out, payload_out, entry_count
//
// an item is handled in the transfer cycle, where every cell compares its key
// and rank position, and then in the update cycle, where the row shifts and the result is
// registered. the next request is taken in the cycle after the update.
// the update waits while a previous result is not yet taken on rsp_.
// reset clears the record count; cell contents need no clearing.
`include "sorted_unique_key_table_unit_defines.svh"
module sorted_unique_key_table_unit import skut_pkg::*; #(
   parameter int CAPACITY = 64,
   parameter int KEY_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OP_W-1:0]      req_operation,
   input  logic signed [KEY_W-1:0] req_key_value,
   input  logic [PAYLOAD_W-1:0] req_payload_in,
   input  logic [RANK_W-1:0]    req_rank_in,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic signed [KEY_W-1:0] rsp_key_out,
   output logic [PAYLOAD_W-1:0] rsp_payload_out,
   output logic [COUNT_W-1:0]   rsp_entry_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      S_IDLE  = 2'b01,
      S_APPLY = 2'b10
   } state_type;

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   op_type                     op_ff, op_in;
   logic signed [KEY_BITS-1:0] key_ff, key_in;
   logic [PAYLOAD_W-1:0]       pay_ff, pay_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   status_type                 status_ff, status_in;
   logic signed [KEY_W-1:0]    key_out_ff, key_out_in;
   logic [PAYLOAD_W-1:0]       pay_out_ff, pay_out_in;
   logic [COUNT_W-1:0]         cnt_out_ff, cnt_out_in;

   logic                       req_xfer;
   logic                       slot_free;
   logic                       apply;
   logic [63:0]                req_key_wide;
   logic signed [KEY_BITS-1:0] req_key;
   cell_ctl_type               ctl;

   logic [CAPACITY-1:0]        occupied;
   logic [CAPACITY-1:0]        lt_v, eq_v, hit_v;
   logic signed [KEY_BITS-1:0] key_v [CAPACITY];
   logic [PAYLOAD_W-1:0]       pay_v [CAPACITY];

   logic                       any_eq, any_hit;
   logic [KEY_BITS-1:0]        hit_key;
   logic [PAYLOAD_W-1:0]       hit_pay;
   logic [63:0]                hit_key_wide;

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign apply     = (state_ff == S_APPLY) && slot_free;

   assign req_key_wide = {32'b0, req_key_value};
   assign req_key      = req_key_wide[KEY_BITS-1:0];

   always_comb begin
      any_eq  = 1'b0;
      any_hit = 1'b0;
      hit_key = '0;
      hit_pay = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         any_eq  = any_eq | eq_v[i];
         any_hit = any_hit | hit_v[i];
         hit_key = hit_key | (hit_v[i] ? key_v[i] : '0);
         hit_pay = hit_pay | (hit_v[i] ? pay_v[i] : '0);
      end
   end

   always_comb begin
      hit_key_wide = '0;
      hit_key_wide[KEY_BITS-1:0] = hit_key;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      pay_in       = pay_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      key_out_in   = key_out_ff;
      pay_out_in   = pay_out_ff;
      cnt_out_in   = cnt_out_ff;
      ctl          = '0;
      if (req_xfer) begin
         op_in       = op_type'(req_operation);
         key_in      = req_key;
         pay_in      = req_payload_in;
         ctl.capture = 1'b1;
         state_in    = S_APPLY;
      end
      if (apply) begin
         key_out_in = '0;
         pay_out_in = '0;
         status_in  = ST_RANK_EMPTY;
         case (op_ff)
            OP_INSERT: begin
               if (any_eq) begin
                  status_in = ST_DUPLICATE;
               end else if (count_ff == CNT_W'(CAPACITY)) begin
                  status_in = ST_FULL;
               end else begin
                  status_in     = ST_INSERTED;
                  ctl.shift_ins = 1'b1;
                  count_in      = count_ff + CNT_W'(1);
               end
            end
            OP_DELETE: begin
               if (any_eq) begin
                  status_in     = ST_DELETED;
                  ctl.shift_del = 1'b1;
                  count_in      = count_ff - CNT_W'(1);
               end else begin
                  status_in = ST_ABSENT;
               end
            end
            OP_QUERY: begin
               if (any_hit) begin
                  status_in  = ST_HIT;
                  key_out_in = hit_key_wide[KEY_W-1:0];
                  pay_out_in = hit_pay;
               end
            end
            default: begin
               status_in = ST_RANK_EMPTY;
            end
         endcase
         cnt_out_in   = COUNT_W'(count_in);
         rsp_valid_in = 1'b1;
         state_in     = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      key_ff     <= key_in;
      pay_ff     <= pay_in;
      status_ff  <= status_in;
      key_out_ff <= key_out_in;
      pay_out_ff <= pay_out_in;
      cnt_out_ff <= cnt_out_in;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                       left_lt;
      logic signed [KEY_BITS-1:0] left_key, right_key;
      logic [PAYLOAD_W-1:0]       left_pay, right_pay;

      assign occupied[i] = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_first
         assign left_lt  = 1'b1;
         assign left_key = key_ff;
         assign left_pay = pay_ff;
      end else begin : g_mid
         assign left_lt  = lt_v[i-1];
         assign left_key = key_v[i-1];
         assign left_pay = pay_v[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_key = key_ff;
         assign right_pay = pay_ff;
      end else begin : g_inner
         assign right_key = key_v[i+1];
         assign right_pay = pay_v[i+1];
      end

      skut_cell #(
         .KEY_BITS (KEY_BITS),
         .INDEX    (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .occupied  (occupied[i]),
         .key_cmp   (req_key),
         .rank_cmp  (req_rank_in),
         .key_new   (key_ff),
         .pay_new   (pay_ff),
         .left_lt   (left_lt),
         .left_key  (left_key),
         .left_pay  (left_pay),
         .right_key (right_key),
         .right_pay (right_pay),
         .lt        (lt_v[i]),
         .eq        (eq_v[i]),
         .hit       (hit_v[i]),
         .key       (key_v[i]),
         .pay       (pay_v[i])
      );
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_key_out     = key_out_ff;
   assign rsp_payload_out = pay_out_ff;
   assign rsp_entry_count = cnt_out_ff;

   // one request in flight at a time
   `SKUT_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)
   // the record count stays within the row
   `SKUT_ASSERT_NOW(a_count_cap, 1'b1, count_ff <= CNT_W'(CAPACITY))
   // the row only changes size in the update cycle
   `SKUT_ASSERT_NEXT(a_idle_count, state_ff == S_IDLE, $stable(count_ff))

endmodule
